### src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define PLF_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("liveness checker: property failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define PLF_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("liveness checker: property failed");

`endif

### src/plfsm_pkg.sv
// Shared types and codes of the probe liveness tracker.
package plfsm_pkg;

	// Event kinds carried by req_type
	typedef enum logic [1:0] {
		EV_SEND    = 2'd0,
		EV_REPLY   = 2'd1,
		EV_TIMEOUT = 2'd2,
		EV_NONE    = 2'd3
	} ev_kind_t;

	// Result status codes
	typedef enum logic [2:0] {
		STS_OK           = 3'd0,
		STS_WRONG_TYPE   = 3'd1,
		STS_SEQ_MISMATCH = 3'd2,
		STS_ID_MISMATCH  = 3'd3,
		STS_SENT         = 3'd4,
		STS_TIMEOUT      = 3'd5
	} status_t;

	// Link state as reported on the result channel
	typedef enum logic [1:0] {
		LINK_INIT = 2'd0,
		LINK_UP   = 2'd1,
		LINK_LOSS = 2'd2,
		LINK_DOWN = 2'd3
	} link_code_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_LOSS_THRESHOLD = 2'd0,
		CFG_PROBE_INTERVAL = 2'd1,
		CFG_ECHO_IDENT     = 2'd2,
		CFG_UNUSED         = 2'd3
	} cfg_index_t;

	localparam int unsigned CfgDataWidth = 16;

	// Reply message type of a valid echo reply
	localparam logic [7:0] EchoReplyKind = 8'd0;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  reply_kind;
		logic [15:0] reply_sequence;
		logic [15:0] reply_ident;
		logic [7:0]  reply_hops;
		logic [3:0]  jitter;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] probe_sequence;
		logic [1:0]  link_state;
		logic [1:0]  prior_state;
		logic [15:0] missed_count;
		logic        period_update;
		logic [15:0] timer_period;
		logic [7:0]  last_hops;
	} rsp_item_t;

	// Configuration values handed from the register file to the core
	typedef struct packed {
		logic [15:0] loss_threshold;
		logic [15:0] probe_interval;
		logic [15:0] echo_ident;
	} cfg_t;

endpackage

### src/probe_target_liveness_fsm.sv
// Top level of the per-target echo-probe liveness tracker.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------
//  req     | req_valid / req_ready   | req (req_item_t), one event
//  rsp     | rsp_valid / rsp_ready   | rsp (rsp_item_t), one result
//  cfg     | cfg_we                  | cfg_index, cfg_data
//
// An event is registered on transfer and updated when it leaves the input register;
// its result is then captured in the output register, which drives rsp_valid.
// One event per cycle is sustained; the input and output registers decouple
// the sides, so req_ready only drops while both hold an item and rsp stalls.
// An event of the unused kind updates nothing and gives no result.
// Reset clears the tracker state and the config registers to their defaults.
module probe_target_liveness_fsm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  plfsm_pkg::req_item_t                req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output plfsm_pkg::rsp_item_t                rsp,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [plfsm_pkg::CfgDataWidth-1:0]  cfg_data
);
	import plfsm_pkg::*;

	logic       valid_s1;
	req_item_t  ev_s1;
	logic       valid_s2;
	rsp_item_t  rsp_s2;
	logic       advance;
	logic       fire;
	logic       has_result;
	rsp_item_t  result;
	cfg_t       cfg;

	plfsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	plfsm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.ev         (ev_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.result     (result)
	);

	// Output register frees up when empty or being taken
	assign advance   = !valid_s2 || rsp_ready;
	assign fire      = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the event on transfer
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			ev_s1 <= req;
		end
	end

	// Output stage control: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire && has_result) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

### src/plfsm_cfg.sv
// Configuration register file of the probe liveness tracker.
module plfsm_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [plfsm_pkg::CfgDataWidth-1:0]   cfg_data,
	output plfsm_pkg::cfg_t                      cfg
);
	import plfsm_pkg::*;

	logic [15:0] loss_threshold_q;
	logic [15:0] probe_interval_q;
	logic [15:0] echo_ident_q;

	// Decode the write; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_threshold_q <= 16'd10;
			probe_interval_q <= 16'd10;
			echo_ident_q     <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_LOSS_THRESHOLD: loss_threshold_q <= cfg_data;
				CFG_PROBE_INTERVAL: probe_interval_q <= cfg_data;
				CFG_ECHO_IDENT:     echo_ident_q     <= cfg_data;
				CFG_UNUSED:         ;
				default:            ;
			endcase
		end
	end

	assign cfg.loss_threshold = loss_threshold_q;
	assign cfg.probe_interval = probe_interval_q;
	assign cfg.echo_ident     = echo_ident_q;

endmodule

### src/plfsm_core.sv
// Tracker state and the per-event update logic.
module plfsm_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  plfsm_pkg::req_item_t  ev,
	input  plfsm_pkg::cfg_t       cfg,
	output logic                  has_result,
	output plfsm_pkg::rsp_item_t  result
);
	import plfsm_pkg::*;

	typedef enum logic [3:0] {
		ST_INIT = 4'b0001,
		ST_UP   = 4'b0010,
		ST_LOSS = 4'b0100,
		ST_DOWN = 4'b1000
	} state_t;

	localparam logic [9:0]  BackoffStep = 10'd15;
	localparam logic [9:0]  BackoffMin  = 10'd10;
	localparam logic [9:0]  BackoffMax  = 10'd600;
	// Excess loss at which the step reaches the ceiling
	localparam logic [16:0] BackoffSat  = 17'(600 / 15);

	state_t      cur_q, cur_d;
	state_t      prev_q, prev_d;
	logic [15:0] loss_q, loss_d;
	logic [15:0] next_seq_q, next_seq_d;
	logic [15:0] sent_seq_q, sent_seq_d;
	logic        seen_q, seen_d;
	logic [7:0]  hops_q, hops_d;
	status_t     status;
	logic        upd;
	logic [15:0] period;

	function automatic link_code_t encode(input state_t s);
		link_code_t c;
		unique case (s)
			ST_INIT: c = LINK_INIT;
			ST_UP:   c = LINK_UP;
			ST_LOSS: c = LINK_LOSS;
			ST_DOWN: c = LINK_DOWN;
			default: c = LINK_INIT;
		endcase
		return c;
	endfunction

	// Linear backoff in tenths, clamped, plus jitter
	function automatic logic [15:0] backoff(input logic [15:0] loss,
			input logic [15:0] thr, input logic [3:0] jit);
		logic [16:0] diff;
		logic [9:0]  base;
		diff = {1'b0, loss} - {1'b0, thr};
		if (loss <= thr) begin
			base = BackoffMin;
		end else if (diff >= BackoffSat) begin
			base = BackoffMax;
		end else begin
			base = 10'(diff[5:0]) * BackoffStep;
		end
		return 16'(base) + 16'(jit);
	endfunction

	// Work out the next state and the result of one event
	always_comb begin
		cur_d      = cur_q;
		prev_d     = prev_q;
		loss_d     = loss_q;
		next_seq_d = next_seq_q;
		sent_seq_d = sent_seq_q;
		seen_d     = seen_q;
		hops_d     = hops_q;
		status     = STS_SENT;
		upd        = 1'b0;
		period     = 16'd0;
		has_result = 1'b1;
		unique case (ev_kind_t'(ev.req_type))
			EV_SEND: begin
				seen_d     = 1'b0;
				sent_seq_d = next_seq_q;
				next_seq_d = next_seq_q + 16'd1;
				status     = STS_SENT;
			end
			EV_REPLY: begin
				hops_d = ev.reply_hops;
				if (ev.reply_kind != EchoReplyKind) begin
					status = STS_WRONG_TYPE;
				end else if (ev.reply_sequence != sent_seq_q) begin
					status = STS_SEQ_MISMATCH;
				end else if (ev.reply_ident != cfg.echo_ident) begin
					status = STS_ID_MISMATCH;
				end else begin
					prev_d = cur_q;
					cur_d  = ST_UP;
					loss_d = 16'd0;
					seen_d = 1'b1;
					upd    = 1'b1;
					period = (cfg.probe_interval == 16'd0) ? 16'd1 : cfg.probe_interval;
					status = STS_OK;
				end
			end
			EV_TIMEOUT: begin
				if (!seen_q) begin
					loss_d = (loss_q == 16'hFFFF) ? loss_q : loss_q + 16'd1;
					if (cur_q == ST_UP) begin
						prev_d = cur_q;
						cur_d  = ST_LOSS;
					end else if (cur_q == ST_LOSS && loss_d > cfg.loss_threshold) begin
						prev_d = cur_q;
						cur_d  = ST_DOWN;
					end
				end
				if (cur_d == ST_DOWN || cur_d == ST_INIT) begin
					upd    = 1'b1;
					period = backoff(loss_d, cfg.loss_threshold, ev.jitter);
				end
				status = STS_TIMEOUT;
			end
			EV_NONE: begin
				has_result = 1'b0;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	// Commit the update when the event leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= ST_INIT;
			prev_q     <= ST_INIT;
			loss_q     <= 16'd0;
			next_seq_q <= 16'd1;
			sent_seq_q <= 16'd1;
			seen_q     <= 1'b0;
			hops_q     <= 8'd0;
		end else if (fire) begin
			cur_q      <= cur_d;
			prev_q     <= prev_d;
			loss_q     <= loss_d;
			next_seq_q <= next_seq_d;
			sent_seq_q <= sent_seq_d;
			seen_q     <= seen_d;
			hops_q     <= hops_d;
		end
	end

	assign result.status         = status;
	assign result.probe_sequence = sent_seq_d;
	assign result.link_state     = encode(cur_d);
	assign result.prior_state    = encode(prev_d);
	assign result.missed_count   = loss_d;
	assign result.period_update  = upd;
	assign result.timer_period   = period;
	assign result.last_hops      = hops_d;

endmodule

### src/plfsm_check.sv
// Port-level checker of the liveness tracker, bound to the top level.
`include "assert_macros.svh"

module plfsm_check (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input plfsm_pkg::rsp_item_t  rsp
);
	import plfsm_pkg::*;

	// A stalled result stays put
	`PLF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// No reload means a zero period
	`PLF_ASSERT_NOW(a_no_reload_zero, rsp_valid && !rsp.period_update, rsp.timer_period == 16'd0)

	// A send never reloads the timer
	`PLF_ASSERT_NOW(a_send_no_reload, rsp_valid && rsp.status == STS_SENT, !rsp.period_update)

	// A good reply leaves the link up with no losses and a reload
	`PLF_ASSERT_NOW(a_reply_ok, rsp_valid && rsp.status == STS_OK, rsp.link_state == LINK_UP && rsp.missed_count == 16'd0 && rsp.period_update)

	// Timeout backoff stays within floor and ceiling plus jitter
	`PLF_ASSERT_NOW(a_backoff_range, rsp_valid && rsp.status == STS_TIMEOUT && rsp.period_update, rsp.timer_period >= 16'd10 && rsp.timer_period <= 16'd615)

endmodule

bind probe_target_liveness_fsm plfsm_check u_plfsm_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
